>>> rtl/crr_pkg.sv
`timescale 1ns / 1ps

package crr_pkg;

   // Default number of fractional bits of the coordinate format.
   localparam int CRR_COORD_FRAC_BITS = 16;

   // Fractional bits of the distortion coefficients.
   localparam int CRR_K_FRAC_BITS = 60;

   // Widths of the configuration port.
   localparam int CRR_CSR_IDX_W  = 3;
   localparam int CRR_CSR_DATA_W = 64;

   // Divider geometry: numerator magnitude, divisor and quotient widths.
   localparam int CRR_NUM_W = 65;
   localparam int CRR_DEN_W = 32;
   localparam int CRR_QUO_W = CRR_NUM_W - CRR_DEN_W;
   localparam int CRR_DIV_LAT = CRR_QUO_W + 1;

   // Latency of the split 64 by 64 multiplier.
   localparam int CRR_MUL_LAT = 2;

   // Register indexes of the configuration port.
   typedef enum logic [CRR_CSR_IDX_W-1:0] {
      REG_FOCAL_X  = 3'd0,
      REG_CENTER_X = 3'd1,
      REG_SHIFT_X  = 3'd2,
      REG_FOCAL_Y  = 3'd3,
      REG_CENTER_Y = 3'd4,
      REG_SHIFT_Y  = 3'd5,
      REG_RADIAL_K1 = 3'd6,
      REG_RADIAL_K2 = 3'd7
   } crr_reg_type;

   typedef struct packed {
      logic signed [63:0] val;
      logic               sat;
   } crr_sat64_type;

   typedef struct packed {
      logic signed [31:0] val;
      logic               sat;
   } crr_sat32_type;

   // Signed value of (+/-) prod >> sh, truncated toward zero, clipped to 64 bits.
   function automatic crr_sat64_type mul_shift_sat(input logic neg,
                                                   input logic [127:0] prod,
                                                   input int sh);
      logic [127:0] m;
      logic [63:0]  lim;
      logic [63:0]  mm;
      crr_sat64_type r;
      m = prod >> sh;
      lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      mm = m[63:0];
      r.sat = 1'b0;
      if ((m[127:64] != 64'd0) || (m[63:0] > lim)) begin
         r.sat = 1'b1;
         mm = lim;
      end
      r.val = neg ? -$signed(mm) : $signed(mm);
      return r;
   endfunction

   // Signed 32-bit projection from quotient magnitude and sign, clipped.
   function automatic crr_sat32_type proj_sat(input logic neg, input logic ovf,
                                              input logic [CRR_QUO_W-1:0] q);
      logic [CRR_QUO_W-1:0] lim;
      logic [CRR_QUO_W-1:0] m;
      crr_sat32_type r;
      lim = neg ? CRR_QUO_W'(33'h0_8000_0000) : CRR_QUO_W'(33'h0_7FFF_FFFF);
      m = q;
      r.sat = 1'b0;
      if (ovf || (q > lim)) begin
         r.sat = 1'b1;
         m = lim;
      end
      r.val = neg ? -$signed(m[31:0]) : $signed(m[31:0]);
      return r;
   endfunction

endpackage

>>> rtl/crr_if.sv
`timescale 1ns / 1ps

// Point and observation channel.
interface crr_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   logic signed [31:0] obs_x;
   logic signed [31:0] obs_y;

   modport source (output valid, point_x, point_y, point_z, obs_x, obs_y,
                   input ready);
   modport sink (input valid, point_x, point_y, point_z, obs_x, obs_y,
                 output ready);
endinterface

// Residual channel.
interface crr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] residual_x;
   logic signed [31:0] residual_y;
   logic               large_error;
   logic               depth_zero;
   logic               saturated;

   modport source (output valid, residual_x, residual_y, large_error, depth_zero,
                   saturated, input ready);
   modport sink (input valid, residual_x, residual_y, large_error, depth_zero,
                 saturated, output ready);
endinterface

// Register write channel.
interface crr_csr_if
   import crr_pkg::*;
;
   logic                      valid;
   logic                      ready;
   logic [CRR_CSR_IDX_W-1:0]  index;
   logic [CRR_CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/crr_mul.sv
`timescale 1ns / 1ps

// Unsigned 64 by 64 multiplier split into four 32 by 32 partial products.
module crr_mul
   import crr_pkg::*;
(
   input  logic         clock,
   input  logic         adv,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic [127:0] prod
);

   logic [63:0]  ll_ff, lh_ff, hl_ff, hh_ff;
   logic [63:0]  ll_in, lh_in, hl_in, hh_in;
   logic [127:0] prod_ff, prod_in;

   // First stage forms the partial products.
   always_comb begin
      ll_in = a[31:0] * b[31:0];
      lh_in = a[31:0] * b[63:32];
      hl_in = a[63:32] * b[31:0];
      hh_in = a[63:32] * b[63:32];
   end

   // Second stage adds them at their weights.
   assign prod_in = {64'd0, ll_ff} + {32'd0, lh_ff, 32'd0} + {32'd0, hl_ff, 32'd0}
                    + {hh_ff, 64'd0};

   always_ff @(posedge clock) begin
      if (adv) begin
         ll_ff   <= ll_in;
         lh_ff   <= lh_in;
         hl_ff   <= hl_in;
         hh_ff   <= hh_in;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

>>> rtl/crr_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage. The first stage checks whether
// the quotient would need more bits than it has and flags that as overflow.
module crr_div
   import crr_pkg::*;
(
   input  logic                 clock,
   input  logic                 adv,
   input  logic [CRR_NUM_W-1:0] num,
   input  logic [CRR_DEN_W-1:0] den,
   output logic [CRR_QUO_W-1:0] quo,
   output logic                 ovf
);

   logic [CRR_DEN_W-1:0] rem_ff [0:CRR_QUO_W];
   logic [CRR_DEN_W-1:0] rem_in [0:CRR_QUO_W];
   logic [CRR_DEN_W-1:0] den_ff [0:CRR_QUO_W];
   logic [CRR_QUO_W-1:0] low_ff [0:CRR_QUO_W];
   logic [CRR_QUO_W-1:0] low_in [0:CRR_QUO_W];
   logic [CRR_QUO_W-1:0] quo_ff [0:CRR_QUO_W];
   logic [CRR_QUO_W-1:0] quo_in [0:CRR_QUO_W];
   logic                 ovf_ff [0:CRR_QUO_W];
   logic                 ovf_in [0:CRR_QUO_W];

   // Each stage shifts in one numerator bit and subtracts the divisor if it fits.
   always_comb begin
      logic [CRR_DEN_W:0] cur;
      logic [CRR_DEN_W:0] diff;
      logic               ge;
      rem_in[0] = num[CRR_NUM_W-1:CRR_QUO_W];
      low_in[0] = num[CRR_QUO_W-1:0];
      quo_in[0] = '0;
      ovf_in[0] = (num[CRR_NUM_W-1:CRR_QUO_W] >= den);
      for (int k = 1; k <= CRR_QUO_W; k++) begin
         cur  = {rem_ff[k-1], low_ff[k-1][CRR_QUO_W-1]};
         diff = cur - {1'b0, den_ff[k-1]};
         ge   = (cur >= {1'b0, den_ff[k-1]});
         rem_in[k] = ge ? diff[CRR_DEN_W-1:0] : cur[CRR_DEN_W-1:0];
         low_in[k] = {low_ff[k-1][CRR_QUO_W-2:0], 1'b0};
         quo_in[k] = {quo_ff[k-1][CRR_QUO_W-2:0], ge};
         ovf_in[k] = ovf_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff[0] <= den;
         for (int k = 0; k <= CRR_QUO_W; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            quo_ff[k] <= quo_in[k];
            ovf_ff[k] <= ovf_in[k];
         end
         for (int k = 1; k <= CRR_QUO_W; k++) begin
            den_ff[k] <= den_ff[k-1];
         end
      end
   end

   assign quo = quo_ff[CRR_QUO_W];
   assign ovf = ovf_ff[CRR_QUO_W];

endmodule

>>> rtl/camera_reprojection_residual.sv
`timescale 1ns / 1ps

// Pinhole reprojection residual with two-term radial distortion.
// Each word on req_chan carries one world point and the pixel where it was seen;
// each word on rsp_chan carries observed minus projected on both axes and the
// large_error, depth_zero and saturated flags, one result word per request word.
// csr_chan writes the eight intrinsic and distortion registers by index; it is
// always ready and should be used only while no point is in flight.
// A result word becomes valid once its request word has passed every stage; with
// the receiver ready it is taken at the next edge. Throughput is one word per
// cycle while the receiver keeps up: the 33-step divider and the multipliers are
// fully pipelined, and the divider stages make up most of the depth.
// Reset empties the pipeline and loads the default intrinsics (focal length
// 900.0, principal point 500.0, no translation, no distortion).
// When the receiver holds rsp_chan.ready low with a result waiting, the whole
// pipeline freezes and req_chan.ready drops until that word is taken; nothing
// in flight is lost or repeated.
module camera_reprojection_residual
   import crr_pkg::*;
#(
   parameter int COORD_FRAC_BITS = CRR_COORD_FRAC_BITS
) (
   input  logic  clock,
   input  logic  reset,
   crr_req_if.sink   req_chan,
   crr_rsp_if.source rsp_chan,
   crr_csr_if.sink   csr_chan
);

   // Pipeline stage numbers.
   localparam int ST_NUM  = 1;
   localparam int ST_PROJ = ST_NUM + CRR_DIV_LAT + 1;
   localparam int ST_SQ   = ST_PROJ + 1;
   localparam int ST_R2   = ST_SQ + 1;
   localparam int ST_T    = ST_R2 + CRR_MUL_LAT + 1;
   localparam int ST_T2   = ST_T + CRR_MUL_LAT + 1;
   localparam int ST_D    = ST_T2 + 1;
   localparam int ST_PR   = ST_D + CRR_MUL_LAT + 1;
   localparam int ST_OUT  = ST_PR + 1;

   localparam logic signed [37:0] THR = 38'sd8 <<< COORD_FRAC_BITS;

   typedef struct packed {
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic               zero;
      logic               sat;
      logic               negx;
      logic               negy;
      logic signed [31:0] xp;
      logic signed [31:0] yp;
      logic [63:0]        r2;
      logic signed [63:0] t1;
      logic signed [63:0] t;
      logic signed [63:0] t2;
      logic signed [63:0] d;
      logic signed [36:0] prx;
      logic signed [36:0] pry;
   } crr_side_type;

   // Configuration registers.
   logic [31:0]        focal_x_ff, center_x_ff, focal_y_ff, center_y_ff;
   logic signed [31:0] shift_x_ff, shift_y_ff;
   logic signed [63:0] radial_k1_ff, radial_k2_ff;

   logic               adv;
   logic [ST_OUT:0]    vld_ff;
   crr_side_type       side_ff [0:ST_PR];
   crr_side_type       side_in [0:ST_PR];

   logic signed [65:0] fpx_ff, czx_ff, fpy_ff, czy_ff;
   logic signed [65:0] fpx_in, czx_in, fpy_in, czy_in;
   logic signed [31:0] pz_ff;
   logic [CRR_NUM_W-1:0] numx_ff, numy_ff, numx_in, numy_in;
   logic [CRR_DEN_W-1:0] dz_ff, dz_in;
   logic [CRR_QUO_W-1:0] quo_x, quo_y;
   logic                 ovf_x, ovf_y;
   logic [62:0]  sqx_ff, sqy_ff;
   logic [63:0]  sqx_full, sqy_full;
   logic [31:0]  axp, ayp;
   logic [63:0]  k1_mag, k2_mag, t_mag, d_mag;
   logic [127:0] prod_k1, prod_k2, prod_t, prod_cx, prod_cy;

   logic signed [31:0] res_x_ff, res_y_ff;
   logic signed [31:0] res_x_in, res_y_in;
   logic               large_ff, zero_ff, sat_ff;
   logic               large_in, sat_in;

   // Configuration writes.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff   <= 32'd58982400;
         center_x_ff  <= 32'd32768000;
         shift_x_ff   <= '0;
         focal_y_ff   <= 32'd58982400;
         center_y_ff  <= 32'd32768000;
         shift_y_ff   <= '0;
         radial_k1_ff <= '0;
         radial_k2_ff <= '0;
      end else if (csr_chan.valid) begin
         case (crr_reg_type'(csr_chan.index))
            REG_FOCAL_X:   focal_x_ff   <= csr_chan.data[31:0];
            REG_CENTER_X:  center_x_ff  <= csr_chan.data[31:0];
            REG_SHIFT_X:   shift_x_ff   <= $signed(csr_chan.data[31:0]);
            REG_FOCAL_Y:   focal_y_ff   <= csr_chan.data[31:0];
            REG_CENTER_Y:  center_y_ff  <= csr_chan.data[31:0];
            REG_SHIFT_Y:   shift_y_ff   <= $signed(csr_chan.data[31:0]);
            REG_RADIAL_K1: radial_k1_ff <= $signed(csr_chan.data);
            REG_RADIAL_K2: radial_k2_ff <= $signed(csr_chan.data);
            default: begin
            end
         endcase
      end
   end

   // The whole pipeline moves together unless a finished word is held.
   assign adv = !vld_ff[ST_OUT] || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[ST_OUT-1:0], req_chan.valid};
      end
   end

   // Stage 0: focal and center products.
   assign fpx_in = $signed({1'b0, focal_x_ff}) * $signed({req_chan.point_x[31],
                                                          req_chan.point_x});
   assign czx_in = $signed({1'b0, center_x_ff}) * $signed({req_chan.point_z[31],
                                                           req_chan.point_z});
   assign fpy_in = $signed({1'b0, focal_y_ff}) * $signed({req_chan.point_y[31],
                                                          req_chan.point_y});
   assign czy_in = $signed({1'b0, center_y_ff}) * $signed({req_chan.point_z[31],
                                                           req_chan.point_z});

   // Stage 1: numerator magnitudes and the divisor magnitude.
   always_comb begin
      logic signed [66:0] nx, ny;
      logic signed [66:0] ax, ay;
      nx = 67'(fpx_ff) + 67'(czx_ff) + (67'(shift_x_ff) <<< COORD_FRAC_BITS);
      ny = 67'(fpy_ff) + 67'(czy_ff) + (67'(shift_y_ff) <<< COORD_FRAC_BITS);
      ax = nx[66] ? -nx : nx;
      ay = ny[66] ? -ny : ny;
      numx_in = ax[CRR_NUM_W-1:0];
      numy_in = ay[CRR_NUM_W-1:0];
      dz_in = pz_ff[31] ? $unsigned(-pz_ff) : $unsigned(pz_ff);
   end

   crr_div u_div_x (
      .clock (clock),
      .adv   (adv),
      .num   (numx_ff),
      .den   (dz_ff),
      .quo   (quo_x),
      .ovf   (ovf_x)
   );

   crr_div u_div_y (
      .clock (clock),
      .adv   (adv),
      .num   (numy_ff),
      .den   (dz_ff),
      .quo   (quo_y),
      .ovf   (ovf_y)
   );

   // Squares of the projections.
   assign axp = side_ff[ST_PROJ].xp[31] ? $unsigned(-side_ff[ST_PROJ].xp)
                                        : $unsigned(side_ff[ST_PROJ].xp);
   assign ayp = side_ff[ST_PROJ].yp[31] ? $unsigned(-side_ff[ST_PROJ].yp)
                                        : $unsigned(side_ff[ST_PROJ].yp);
   assign sqx_full = axp * axp;
   assign sqy_full = ayp * ayp;

   // Coefficient and term magnitudes for the multipliers.
   assign k1_mag = radial_k1_ff[63] ? $unsigned(-radial_k1_ff) : $unsigned(radial_k1_ff);
   assign k2_mag = radial_k2_ff[63] ? $unsigned(-radial_k2_ff) : $unsigned(radial_k2_ff);
   assign t_mag  = side_ff[ST_T].t[63] ? $unsigned(-side_ff[ST_T].t)
                                       : $unsigned(side_ff[ST_T].t);
   assign d_mag  = side_ff[ST_D].d[63] ? $unsigned(-side_ff[ST_D].d)
                                       : $unsigned(side_ff[ST_D].d);

   crr_mul u_mul_k1 (
      .clock (clock), .adv (adv), .a (k1_mag), .b (side_ff[ST_R2].r2), .prod (prod_k1)
   );

   crr_mul u_mul_k2 (
      .clock (clock), .adv (adv), .a (k2_mag), .b (side_ff[ST_R2].r2), .prod (prod_k2)
   );

   crr_mul u_mul_t (
      .clock (clock), .adv (adv), .a (t_mag), .b (side_ff[ST_T].r2), .prod (prod_t)
   );

   crr_mul u_mul_cx (
      .clock (clock), .adv (adv),
      .a ({32'd0, (side_ff[ST_D].xp[31] ? $unsigned(-side_ff[ST_D].xp)
                                        : $unsigned(side_ff[ST_D].xp))}),
      .b (d_mag), .prod (prod_cx)
   );

   crr_mul u_mul_cy (
      .clock (clock), .adv (adv),
      .a ({32'd0, (side_ff[ST_D].yp[31] ? $unsigned(-side_ff[ST_D].yp)
                                        : $unsigned(side_ff[ST_D].yp))}),
      .b (d_mag), .prod (prod_cy)
   );

   // Values that travel along the pipeline, updated at the stage that makes them.
   always_comb begin
      crr_sat32_type px, py;
      crr_sat64_type s1, s2, s3;
      logic signed [64:0] dsum;
      logic [34:0]        cmx, cmy;
      logic signed [35:0] cx, cy;

      side_in[0] = '0;
      side_in[0].ox   = req_chan.obs_x;
      side_in[0].oy   = req_chan.obs_y;
      side_in[0].zero = (req_chan.point_z == 32'sd0);
      for (int i = 1; i <= ST_PR; i++) begin
         side_in[i] = side_ff[i-1];
      end

      // Sign of each quotient.
      side_in[ST_NUM].negx = (fpx_ff + czx_ff + (66'(shift_x_ff) <<< COORD_FRAC_BITS) < 0)
                             != pz_ff[31];
      side_in[ST_NUM].negy = (fpy_ff + czy_ff + (66'(shift_y_ff) <<< COORD_FRAC_BITS) < 0)
                             != pz_ff[31];

      // Clip the quotients to the coordinate range.
      px = proj_sat(side_ff[ST_PROJ-1].negx, ovf_x, quo_x);
      py = proj_sat(side_ff[ST_PROJ-1].negy, ovf_y, quo_y);
      side_in[ST_PROJ].xp  = px.val;
      side_in[ST_PROJ].yp  = py.val;
      side_in[ST_PROJ].sat = side_ff[ST_PROJ-1].sat | px.sat | py.sat;

      // Squared radius.
      side_in[ST_R2].r2 = {1'b0, sqx_ff} + {1'b0, sqy_ff};

      // Second- and fourth-order coefficient products.
      s1 = mul_shift_sat(radial_k1_ff[63], prod_k1, 2 * COORD_FRAC_BITS);
      s2 = mul_shift_sat(radial_k2_ff[63], prod_k2, 2 * COORD_FRAC_BITS);
      side_in[ST_T].t1  = s1.val;
      side_in[ST_T].t   = s2.val;
      side_in[ST_T].sat = side_ff[ST_T-1].sat | s1.sat | s2.sat;

      // Fourth-order term times the radius once more.
      s3 = mul_shift_sat(side_ff[ST_T2-1].t[63], prod_t, 2 * COORD_FRAC_BITS);
      side_in[ST_T2].t2  = s3.val;
      side_in[ST_T2].sat = side_ff[ST_T2-1].sat | s3.sat;

      // Distortion factor, clipped to the coefficient range.
      dsum = 65'(side_ff[ST_D-1].t1) + 65'(side_ff[ST_D-1].t2);
      if (!dsum[64] && dsum[63]) begin
         side_in[ST_D].d   = 64'sh7FFF_FFFF_FFFF_FFFF;
         side_in[ST_D].sat = 1'b1;
      end else if (dsum[64] && !dsum[63]) begin
         side_in[ST_D].d   = 64'sh8000_0000_0000_0000;
         side_in[ST_D].sat = 1'b1;
      end else begin
         side_in[ST_D].d = dsum[63:0];
      end

      // Distorted projection at full width.
      cmx = 35'(prod_cx >> CRR_K_FRAC_BITS);
      cmy = 35'(prod_cy >> CRR_K_FRAC_BITS);
      cx = (side_ff[ST_PR-1].xp[31] != side_ff[ST_PR-1].d[63]) ? -$signed({1'b0, cmx})
                                                                : $signed({1'b0, cmx});
      cy = (side_ff[ST_PR-1].yp[31] != side_ff[ST_PR-1].d[63]) ? -$signed({1'b0, cmy})
                                                                : $signed({1'b0, cmy});
      side_in[ST_PR].prx = 37'(side_ff[ST_PR-1].xp) + 37'(cx);
      side_in[ST_PR].pry = 37'(side_ff[ST_PR-1].yp) + 37'(cy);
   end

   // Residuals, threshold compare and the zero-depth override.
   always_comb begin
      logic signed [37:0] dfx, dfy, rx, ry;
      dfx = 38'(side_ff[ST_PR].prx) - 38'(side_ff[ST_PR].ox);
      dfy = 38'(side_ff[ST_PR].pry) - 38'(side_ff[ST_PR].oy);
      rx = -dfx;
      ry = -dfy;
      sat_in = side_ff[ST_PR].sat;
      if (rx > 38'sh0_7FFF_FFFF) begin
         res_x_in = 32'sh7FFF_FFFF;
         sat_in = 1'b1;
      end else if (rx < -38'sh0_8000_0000) begin
         res_x_in = 32'sh8000_0000;
         sat_in = 1'b1;
      end else begin
         res_x_in = rx[31:0];
      end
      if (ry > 38'sh0_7FFF_FFFF) begin
         res_y_in = 32'sh7FFF_FFFF;
         sat_in = 1'b1;
      end else if (ry < -38'sh0_8000_0000) begin
         res_y_in = 32'sh8000_0000;
         sat_in = 1'b1;
      end else begin
         res_y_in = ry[31:0];
      end
      large_in = (dfx > THR) || (dfy > THR);
      if (side_ff[ST_PR].zero) begin
         res_x_in = '0;
         res_y_in = '0;
         large_in = 1'b0;
         sat_in   = 1'b0;
      end
   end

   // Payload registers of every stage.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= ST_PR; i++) begin
            side_ff[i] <= side_in[i];
         end
         fpx_ff   <= fpx_in;
         czx_ff   <= czx_in;
         fpy_ff   <= fpy_in;
         czy_ff   <= czy_in;
         pz_ff    <= req_chan.point_z;
         numx_ff  <= numx_in;
         numy_ff  <= numy_in;
         dz_ff    <= dz_in;
         sqx_ff   <= sqx_full[62:0];
         sqy_ff   <= sqy_full[62:0];
         res_x_ff <= res_x_in;
         res_y_ff <= res_y_in;
         large_ff <= large_in;
         zero_ff  <= side_ff[ST_PR].zero;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_chan.valid       = vld_ff[ST_OUT];
   assign rsp_chan.residual_x  = res_x_ff;
   assign rsp_chan.residual_y  = res_y_ff;
   assign rsp_chan.large_error = large_ff;
   assign rsp_chan.depth_zero  = zero_ff;
   assign rsp_chan.saturated   = sat_ff;

   // A held result word freezes every stage.
   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_OUT] && !rsp_chan.ready |=> $stable(vld_ff))
      else $error("pipeline moved while the result word was held");

   // An accepted word enters the first stage.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> vld_ff[0])
      else $error("accepted word did not enter the pipeline");

   // Zero depth gives a clean zero result.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.depth_zero |->
         rsp_chan.residual_x == 32'sd0 && rsp_chan.residual_y == 32'sd0 &&
         !rsp_chan.large_error && !rsp_chan.saturated)
      else $error("zero-depth result is not clean");

   // A large error means the projection lies past the observation.
   a_large: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.large_error |->
         rsp_chan.residual_x[31] || rsp_chan.residual_y[31])
      else $error("large error flagged with no negative residual");

endmodule
